/* src/cbo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbo_pkg: shared types and constants for the circle/box overlap test
// Coordinate width, derived datapath widths and pipeline stage records.
// ----------------------------------------------------------------------------
package cbo_pkg;

	localparam int COORD_BITS = 16;
	localparam int NCORNER    = 4;
	localparam int NSTG       = 6;

	// corner order around the box; edge e runs from corner e to corner (e+1) mod 4
	localparam int CRN_TL = 0;
	localparam int CRN_TR = 1;
	localparam int CRN_BR = 2;
	localparam int CRN_BL = 3;

	localparam int DW  = COORD_BITS + 1;       // coordinate difference
	localparam int SQW = 2 * COORD_BITS;       // square of a difference
	localparam int PW  = 2 * COORD_BITS + 1;   // signed cross term
	localparam int D2W = 2 * COORD_BITS + 1;   // sum of two squares
	localparam int R2W = 2 * COORD_BITS - 1;   // radius squared
	localparam int CRW = 2 * COORD_BITS + 1;   // cross product magnitude
	localparam int LOW = COORD_BITS + 1;       // low half of a split operand
	localparam int CHW = CRW - LOW;            // high half of a split operand
	localparam int LHW = 4 * COORD_BITS + 2;   // final compare width

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DW-1:0]         diff_t;
	typedef logic        [SQW-1:0]        sq_t;
	typedef logic signed [PW-1:0]         prod_t;
	typedef logic        [D2W-1:0]        d2_t;
	typedef logic        [R2W-1:0]        r2_t;
	typedef logic        [CRW-1:0]        crmag_t;
	typedef logic        [2*CHW-1:0]      hh_t;
	typedef logic        [CHW+LOW-1:0]    hl_t;
	typedef logic        [2*LOW-1:0]      ll_t;
	typedef logic        [R2W+CHW-1:0]    rh_t;
	typedef logic        [R2W+LOW-1:0]    rl_t;
	typedef logic        [LHW-1:0]        wide_t;

	typedef struct packed {
		coord_t center_x;
		coord_t center_y;
		coord_t radius;
		coord_t top_left_x;
		coord_t top_left_y;
		coord_t top_right_x;
		coord_t top_right_y;
		coord_t bottom_left_x;
		coord_t bottom_left_y;
		coord_t bottom_right_x;
		coord_t bottom_right_y;
	} shape_t;

	typedef struct packed {
		logic [NSTG-1:0] ld;    // stage register loads this cycle
		logic [NSTG-1:0] vld;   // stage register holds a word
	} pipe_ctl_t;

	typedef struct packed {
		diff_t [NCORNER-1:0]   dx;     // center minus corner
		diff_t [NCORNER-1:0]   dy;
		diff_t [NCORNER-1:0]   vx;     // edge vector
		diff_t [NCORNER-1:0]   vy;
		logic [COORD_BITS-1:0] rmag;
		logic                  in_box;
		logic [NCORNER-1:0]    chk;    // edge needs the distance test
	} s1_t;

	typedef struct packed {
		sq_t [NCORNER-1:0]   dxsq;
		sq_t [NCORNER-1:0]   dysq;
		prod_t [NCORNER-1:0] px;
		prod_t [NCORNER-1:0] py;
		sq_t [NCORNER-1:0]   vxsq;
		sq_t [NCORNER-1:0]   vysq;
		r2_t                 r2;
		logic                in_box;
		logic [NCORNER-1:0]  chk;
	} s2_t;

	typedef struct packed {
		crmag_t [NCORNER-1:0] crmag;
		d2_t [NCORNER-1:0]    len2;
		r2_t                  r2;
		logic                 early;  // inside or an endpoint within radius
		logic [NCORNER-1:0]   chk;
	} s3_t;

	typedef struct packed {
		hh_t [NCORNER-1:0]  hh;
		hl_t [NCORNER-1:0]  hl;
		ll_t [NCORNER-1:0]  ll;
		rh_t [NCORNER-1:0]  rh;
		rl_t [NCORNER-1:0]  rl;
		logic               early;
		logic [NCORNER-1:0] chk;
	} s4_t;

	typedef struct packed {
		wide_t [NCORNER-1:0] lhs;
		wide_t [NCORNER-1:0] rhs;
		logic                early;
		logic [NCORNER-1:0]  chk;
	} s5_t;

endpackage

/* src/cbo_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbo_if: valid/ready channels of the circle/box overlap test
// Shape word channel and result word channel.
// ----------------------------------------------------------------------------
interface cbo_in_if
	import cbo_pkg::*;
();
	logic   valid;
	logic   ready;
	coord_t center_x;
	coord_t center_y;
	coord_t radius;
	coord_t top_left_x;
	coord_t top_left_y;
	coord_t top_right_x;
	coord_t top_right_y;
	coord_t bottom_left_x;
	coord_t bottom_left_y;
	coord_t bottom_right_x;
	coord_t bottom_right_y;

	modport source (
		output valid, center_x, center_y, radius, top_left_x, top_left_y,
		       top_right_x, top_right_y, bottom_left_x, bottom_left_y,
		       bottom_right_x, bottom_right_y,
		input  ready
	);
	modport sink (
		input  valid, center_x, center_y, radius, top_left_x, top_left_y,
		       top_right_x, top_right_y, bottom_left_x, bottom_left_y,
		       bottom_right_x, bottom_right_y,
		output ready
	);
endinterface

interface cbo_out_if;
	logic valid;
	logic ready;
	logic collides;

	modport source (output valid, collides, input ready);
	modport sink (input valid, collides, output ready);
endinterface

/* src/cbo_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbo_ctrl: pipeline valid bits and per-stage load enables
// A stage loads when it is empty or the stage after it moves on.
// ----------------------------------------------------------------------------
module cbo_ctrl
	import cbo_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output pipe_ctl_t ctl
);

	logic [NSTG-1:0] vld_q;
	logic [NSTG:0]   en;

	always_comb begin
		en[NSTG] = out_ready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign ctl.ld    = en[NSTG-1:0];
	assign ctl.vld   = vld_q;
	assign in_ready  = en[0];
	assign out_valid = vld_q[NSTG-1];

endmodule

/* src/cbo_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbo_front: stages 1 to 3 of the overlap datapath
// Differences, squares and cross terms, endpoint tests, cross magnitude.
// ----------------------------------------------------------------------------
module cbo_front
	import cbo_pkg::*;
(
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  shape_t    shp,
	output s3_t       s3
);

	s1_t s1_d, s1_s1;
	s2_t s2_d, s2_s2;
	s3_t s3_d, s3_s3;

	coord_t [NCORNER-1:0] cxs, cys;

	// stage 1: differences, inside and between tests
	always_comb begin
		int nx;
		cxs[CRN_TL] = shp.top_left_x;
		cys[CRN_TL] = shp.top_left_y;
		cxs[CRN_TR] = shp.top_right_x;
		cys[CRN_TR] = shp.top_right_y;
		cxs[CRN_BR] = shp.bottom_right_x;
		cys[CRN_BR] = shp.bottom_right_y;
		cxs[CRN_BL] = shp.bottom_left_x;
		cys[CRN_BL] = shp.bottom_left_y;
		s1_d = '0;
		for (int k = 0; k < NCORNER; k++) begin
			s1_d.dx[k] = DW'(shp.center_x) - DW'(cxs[k]);
			s1_d.dy[k] = DW'(shp.center_y) - DW'(cys[k]);
		end
		for (int e = 0; e < NCORNER; e++) begin
			nx = (e == NCORNER - 1) ? 0 : e + 1;
			s1_d.vx[e] = DW'(cxs[nx]) - DW'(cxs[e]);
			s1_d.vy[e] = DW'(cys[nx]) - DW'(cys[e]);
			s1_d.chk[e] = !((cxs[nx] == cxs[e]) && (cys[nx] == cys[e])) &&
				(((shp.center_x >= cxs[e]) && (shp.center_x <= cxs[nx])) ||
				 ((shp.center_x >= cxs[nx]) && (shp.center_x <= cxs[e])) ||
				 ((shp.center_y >= cys[e]) && (shp.center_y <= cys[nx])) ||
				 ((shp.center_y >= cys[nx]) && (shp.center_y <= cys[e])));
		end
		s1_d.rmag = shp.radius[COORD_BITS-1] ? (~shp.radius + 1'b1) : shp.radius;
		s1_d.in_box = (shp.center_x >= shp.top_left_x) &&
			(shp.center_x <= shp.top_right_x) &&
			(shp.center_y >= shp.bottom_left_y) &&
			(shp.center_y <= shp.top_left_y);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[0]) begin
			s1_s1 <= s1_d;
		end
	end

	// stage 2: all first-level products
	always_comb begin
		for (int k = 0; k < NCORNER; k++) begin
			s2_d.dxsq[k] = SQW'(s1_s1.dx[k] * s1_s1.dx[k]);
			s2_d.dysq[k] = SQW'(s1_s1.dy[k] * s1_s1.dy[k]);
			s2_d.px[k]   = PW'(s1_s1.vx[k] * s1_s1.dy[k]);
			s2_d.py[k]   = PW'(s1_s1.vy[k] * s1_s1.dx[k]);
			s2_d.vxsq[k] = SQW'(s1_s1.vx[k] * s1_s1.vx[k]);
			s2_d.vysq[k] = SQW'(s1_s1.vy[k] * s1_s1.vy[k]);
		end
		s2_d.r2     = R2W'(s1_s1.rmag * s1_s1.rmag);
		s2_d.in_box = s1_s1.in_box;
		s2_d.chk    = s1_s1.chk;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[1]) begin
			s2_s2 <= s2_d;
		end
	end

	// stage 3: endpoint distances, cross magnitude, edge length squared
	always_comb begin
		logic [NCORNER-1:0] near;
		logic signed [CRW:0] cr;
		d2_t d2;
		for (int k = 0; k < NCORNER; k++) begin
			d2 = D2W'(s2_s2.dxsq[k]) + D2W'(s2_s2.dysq[k]);
			near[k] = (d2 <= D2W'(s2_s2.r2));
		end
		for (int e = 0; e < NCORNER; e++) begin
			cr = (CRW + 1)'(s2_s2.px[e]) - (CRW + 1)'(s2_s2.py[e]);
			s3_d.crmag[e] = cr[CRW] ? CRW'(-cr) : CRW'(cr);
			s3_d.len2[e]  = D2W'(s2_s2.vxsq[e]) + D2W'(s2_s2.vysq[e]);
		end
		s3_d.r2    = s2_s2.r2;
		s3_d.early = s2_s2.in_box || (|near);
		s3_d.chk   = s2_s2.chk;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[2]) begin
			s3_s3 <= s3_d;
		end
	end

	assign s3 = s3_s3;

endmodule

/* src/cbo_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbo_back: stages 4 to 6 of the overlap datapath
// Split products of cross^2 and r^2*len^2, their sums, final decision.
// ----------------------------------------------------------------------------
module cbo_back
	import cbo_pkg::*;
(
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  s3_t       s3,
	output logic      hit
);

	s4_t  s4_d, s4_s4;
	s5_t  s5_d, s5_s5;
	logic hit_d, hit_s6;

	// stage 4: partial products on half-width operands
	always_comb begin
		logic [CHW-1:0] ch, lh;
		logic [LOW-1:0] cl, lw;
		for (int e = 0; e < NCORNER; e++) begin
			ch = s3.crmag[e][CRW-1:LOW];
			cl = s3.crmag[e][LOW-1:0];
			lh = s3.len2[e][D2W-1:LOW];
			lw = s3.len2[e][LOW-1:0];
			s4_d.hh[e] = ch * ch;
			s4_d.hl[e] = ch * cl;
			s4_d.ll[e] = cl * cl;
			s4_d.rh[e] = s3.r2 * lh;
			s4_d.rl[e] = s3.r2 * lw;
		end
		s4_d.early = s3.early;
		s4_d.chk   = s3.chk;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[3]) begin
			s4_s4 <= s4_d;
		end
	end

	// stage 5: recombine; cross term appears twice, hence the extra shift
	always_comb begin
		for (int e = 0; e < NCORNER; e++) begin
			s5_d.lhs[e] = (LHW'(s4_s4.hh[e]) << (2 * LOW)) +
				(LHW'(s4_s4.hl[e]) << (LOW + 1)) + LHW'(s4_s4.ll[e]);
			s5_d.rhs[e] = (LHW'(s4_s4.rh[e]) << LOW) + LHW'(s4_s4.rl[e]);
		end
		s5_d.early = s4_s4.early;
		s5_d.chk   = s4_s4.chk;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[4]) begin
			s5_s5 <= s5_d;
		end
	end

	// stage 6: line distance test, result register
	always_comb begin
		logic [NCORNER-1:0] close;
		for (int e = 0; e < NCORNER; e++) begin
			close[e] = s5_s5.chk[e] && (s5_s5.lhs[e] <= s5_s5.rhs[e]);
		end
		hit_d = s5_s5.early || (|close);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[5]) begin
			hit_s6 <= hit_d;
		end
	end

	assign hit = hit_s6;

endmodule

/* src/circle_box_overlap_test_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_box_overlap_test_core: circle versus axis-aligned box overlap
//
// Usage:
//   shape  (sink)  : one word per test, circle center and radius plus the
//                    four box corners, signed Q12.4. Taken when valid and
//                    ready are both high at a rising clk edge.
//   result (source): one word per shape word, collides = 1 on overlap,
//                    in the same order as the shapes were taken.
//   Pipeline: six register stages, s1 to s5 and the result register; a result
//   word becomes valid when its shape word reaches the result register.
//   Throughput: one word per cycle while result.ready is high, when every stage
//   takes a new word each cycle; no multiplier is wider than 31x17 bits.
//   Stall: when result.ready is low the held word waits in the output stage;
//   each earlier stage keeps filling while it has an empty slot, so up to six
//   words are held. shape.ready drops only when the whole pipe is full.
//   Reset: arst_n clears all valid bits at once; data registers are not
//   reset. No configuration and no state carried between words.
// ----------------------------------------------------------------------------
module circle_box_overlap_test_core
	import cbo_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	cbo_in_if.sink   shape,
	cbo_out_if.source result
);

	pipe_ctl_t ctl;
	shape_t    shp;
	s3_t       s3;

	// gather the shape word into one bundle for the datapath
	assign shp.center_x       = shape.center_x;
	assign shp.center_y       = shape.center_y;
	assign shp.radius         = shape.radius;
	assign shp.top_left_x     = shape.top_left_x;
	assign shp.top_left_y     = shape.top_left_y;
	assign shp.top_right_x    = shape.top_right_x;
	assign shp.top_right_y    = shape.top_right_y;
	assign shp.bottom_left_x  = shape.bottom_left_x;
	assign shp.bottom_left_y  = shape.bottom_left_y;
	assign shp.bottom_right_x = shape.bottom_right_x;
	assign shp.bottom_right_y = shape.bottom_right_y;

	// valid bits and load enables; the ready chain lets bubbles collapse
	cbo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (shape.valid),
		.in_ready  (shape.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.ctl       (ctl)
	);

	// stages 1-3: differences, first products, endpoint tests, |cross|
	cbo_front u_front (
		.clk (clk),
		.ctl (ctl),
		.shp (shp),
		.s3  (s3)
	);

	// stages 4-6: cross^2 against r^2*len^2, final result register
	cbo_back u_back (
		.clk (clk),
		.ctl (ctl),
		.s3  (s3),
		.hit (result.collides)
	);

	// a ready output lets every stage advance, so input must be ready
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		result.ready |-> shape.ready)
		else $error("shape not ready while result side is ready");

	// a taken word lands in stage 1
	a_take_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(shape.valid && shape.ready) |=> ctl.vld[0])
		else $error("accepted word lost at stage 1");

	// full pipe with a stalled output must back-pressure the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		((&ctl.vld) && !result.ready) |-> !shape.ready)
		else $error("input taken while pipe full and stalled");

	// an occupied stage that does not load keeps its word
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.vld[0] && !ctl.ld[0]) |=> ctl.vld[0])
		else $error("stage 1 word dropped during stall");

endmodule
